// File: design/gmv_pkg.sv
// ----------------------------------------------------------------------------
// gmv_pkg
// Shared widths, register codes, reset values and types for the gain, mute
// and voice-operated push-to-talk block.
// ----------------------------------------------------------------------------
package gmv_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC      = 14;
   localparam int THR_BITS       = 16;
   localparam int THR_FRAC       = 15;
   localparam int HANG_BITS      = 16;
   localparam int SINCE_BITS     = 17;
   localparam int MODE_BITS      = 2;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Peak and threshold are compared on a common scale of this width.
   localparam int CMP_BITS = SAMPLE_BITS + THR_FRAC;

   localparam logic [SINCE_BITS-1:0] SINCE_MAX = {SINCE_BITS{1'b1}};

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(16384);
   localparam logic [THR_BITS-1:0]  THR_RESET  = THR_BITS'(1024);
   localparam logic [HANG_BITS-1:0] HANG_RESET = HANG_BITS'(500);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GAIN      = 3'd0,
      CSR_MUTE      = 3'd1,
      CSR_KEY_MODE  = 3'd2,
      CSR_PTT_ARMED = 3'd3,
      CSR_THRESHOLD = 3'd4,
      CSR_HANG      = 3'd5
   } csr_index_type;

   typedef enum logic [MODE_BITS-1:0] {
      KEY_MODE_HID    = 2'd0,
      KEY_MODE_SERIAL = 2'd1,
      KEY_MODE_VOX    = 2'd2
   } key_mode_type;

   typedef struct packed {
      logic [GAIN_BITS-1:0] gain_q14;
      logic                 mute;
      logic [MODE_BITS-1:0] key_mode;
      logic                 ptt_armed;
      logic [THR_BITS-1:0]  vox_threshold;
      logic [HANG_BITS-1:0] hang_ms;
   } cfg_type;

endpackage

// File: design/gmv_csr.sv
// ----------------------------------------------------------------------------
// gmv_csr
// Configuration register file: decodes index writes into the settings struct.
// ----------------------------------------------------------------------------
module gmv_csr
   import gmv_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            CSR_GAIN:      cfg_in.gain_q14      = csr_wdata[GAIN_BITS-1:0];
            CSR_MUTE:      cfg_in.mute          = csr_wdata[0];
            CSR_KEY_MODE:  cfg_in.key_mode      = csr_wdata[MODE_BITS-1:0];
            CSR_PTT_ARMED: cfg_in.ptt_armed     = csr_wdata[0];
            CSR_THRESHOLD: cfg_in.vox_threshold = csr_wdata[THR_BITS-1:0];
            CSR_HANG:      cfg_in.hang_ms       = csr_wdata[HANG_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_q14      <= GAIN_RESET;
         cfg_ff.mute          <= 1'b0;
         cfg_ff.key_mode      <= KEY_MODE_HID;
         cfg_ff.ptt_armed     <= 1'b0;
         cfg_ff.vox_threshold <= THR_RESET;
         cfg_ff.hang_ms       <= HANG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ap_gain_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && csr_index == CSR_GAIN) |=> cfg_ff.gain_q14 == $past(csr_wdata[GAIN_BITS-1:0]))
      else $error("gain register did not take the written value");

   ap_no_write_hold: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> cfg_ff == $past(cfg_ff))
      else $error("settings changed without a write transfer");

   ap_bad_index_hold: assert property (@(posedge clock) disable iff (reset)
      (wr_en && csr_index > CSR_HANG) |=> cfg_ff == $past(cfg_ff))
      else $error("write to an unused index changed the settings");

endmodule

// File: design/gmv_scale.sv
// ----------------------------------------------------------------------------
// gmv_scale
// Q2.14 gain multiply with round-half-up, saturation and magnitude.
// ----------------------------------------------------------------------------
module gmv_scale
   import gmv_pkg::*;
(
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic        [GAIN_BITS-1:0]   gain_q14,
   input  logic                          mute,
   output logic signed [SAMPLE_BITS-1:0] scaled,
   output logic        [SAMPLE_BITS-1:0] mag
);

   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
   localparam int Q_BITS    = PROD_BITS - GAIN_FRAC;

   localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
      PROD_BITS'(1 << (GAIN_FRAC - 1));
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX =
      {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
      {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   logic signed [GAIN_BITS:0]     gain_s;
   logic signed [PROD_BITS-1:0]   sample_x;
   logic signed [PROD_BITS-1:0]   prod;
   logic signed [PROD_BITS-1:0]   biased;
   logic signed [Q_BITS-1:0]      quot;
   logic                          in_range;

   assign gain_s   = mute ? '0 : $signed({1'b0, gain_q14});
   assign sample_x = PROD_BITS'(sample);
   assign prod     = sample_x * PROD_BITS'(gain_s);
   assign biased   = prod + ROUND_HALF;
   // floor division by 2^14: drop the fraction bits of the biased product
   assign quot     = $signed(biased[PROD_BITS-1:GAIN_FRAC]);

   // in range when all bits above the sample's sign bit copy it
   assign in_range = (quot[Q_BITS-1:SAMPLE_BITS-1] == '0) ||
                     (quot[Q_BITS-1:SAMPLE_BITS-1] == '1);

   always_comb begin
      if (in_range) begin
         scaled = quot[SAMPLE_BITS-1:0];
      end else if (quot[Q_BITS-1]) begin
         scaled = SAMPLE_MIN;
      end else begin
         scaled = SAMPLE_MAX;
      end
   end

   // the most negative value wraps to 2^(SAMPLE_BITS-1), correct as unsigned
   assign mag = scaled[SAMPLE_BITS-1] ? SAMPLE_BITS'(~scaled + 1'b1) : scaled;

endmodule

// File: design/gmv_vox.sv
// ----------------------------------------------------------------------------
// gmv_vox
// Buffer peak tracker, millisecond hang counter and push-to-talk decision.
// ----------------------------------------------------------------------------
module gmv_vox
   import gmv_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   upd,
   input  logic                   tick,
   input  logic                   last,
   input  logic [SAMPLE_BITS-1:0] mag,
   output logic                   ptt_nx
);

   logic [SAMPLE_BITS-1:0] peak_ff, peak_in, peak_max;
   logic [SINCE_BITS-1:0]  since_ff, since_in;
   logic                   ptt_on_ff, ptt_in;
   logic                   vox, ptt_base, keyed;
   logic [CMP_BITS-1:0]    peak_cmp, thr_cmp;

   assign vox      = (cfg.key_mode == KEY_MODE_VOX);
   assign ptt_base = vox ? ptt_on_ff : cfg.ptt_armed;
   assign peak_max = (mag > peak_ff) ? mag : peak_ff;

   // peak / 2^(SAMPLE_BITS-1) >= threshold / 2^15, cross-multiplied
   assign peak_cmp = {peak_max, {THR_FRAC{1'b0}}};
   assign thr_cmp  = CMP_BITS'({cfg.vox_threshold, {(SAMPLE_BITS-1){1'b0}}});
   assign keyed    = (peak_cmp >= thr_cmp);

   always_comb begin
      peak_in  = peak_ff;
      since_in = since_ff;
      ptt_in   = ptt_base;
      if (tick) begin
         if (since_ff != SINCE_MAX) begin
            since_in = since_ff + 1'b1;
         end
      end else if (last) begin
         peak_in = '0;
         if (vox) begin
            if (keyed) begin
               ptt_in   = 1'b1;
               since_in = '0;
            end else if (cfg.hang_ms == '0) begin
               ptt_in = 1'b0;
            end else if (ptt_base && (since_ff > SINCE_BITS'(cfg.hang_ms))) begin
               ptt_in = 1'b0;
            end
         end
      end else begin
         peak_in = peak_max;
      end
   end

   assign ptt_nx = ptt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff   <= '0;
         since_ff  <= SINCE_MAX;
         ptt_on_ff <= 1'b0;
      end else if (upd) begin
         peak_ff   <= peak_in;
         since_ff  <= since_in;
         ptt_on_ff <= ptt_in;
      end
   end

   ap_manual_follows_armed: assert property (@(posedge clock) disable iff (reset)
      (upd && !vox) |=> ptt_on_ff == $past(cfg.ptt_armed))
      else $error("manual mode push-to-talk does not follow the armed flag");

   ap_buffer_end_clears_peak: assert property (@(posedge clock) disable iff (reset)
      (upd && !tick && last) |=> peak_ff == '0)
      else $error("peak not cleared at buffer end");

   ap_tick_keeps_peak: assert property (@(posedge clock) disable iff (reset)
      (upd && tick) |=> $stable(peak_ff))
      else $error("tick changed the buffer peak");

   ap_key_clears_hang: assert property (@(posedge clock) disable iff (reset)
      (upd && !tick && last && vox && keyed) |=> (since_ff == '0 && ptt_on_ff))
      else $error("voice detect did not key and clear the hang count");

endmodule

// File: design/gain_mute_with_vox_ptt.sv
// ----------------------------------------------------------------------------
// gain_mute_with_vox_ptt
// Audio gain and mute with saturation, plus manual or voice-operated
// push-to-talk with a hang time counted in millisecond ticks.
// ----------------------------------------------------------------------------
// Path: an accepted item waits in the input register, then moves into the
//   result register on rsp_* once the result slot is free or being taken.
// Throughput: one item per cycle unless stalled; the input register feeds one pass of
//   multiply, round, saturate, peak and key decision into the result register.
// Reset (synchronous): settings return to their defaults, peak to zero, the
//   hang count to its saturated value, push-to-talk off, both stages empty.
// ----------------------------------------------------------------------------
module gain_mute_with_vox_ptt
   import gmv_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic signed [SAMPLE_BITS-1:0] req_sample_in,
   input  logic                          req_buffer_end,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_sample_out,
   output logic                          rsp_sample_valid,
   output logic                          rsp_ptt,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   cfg_type cfg;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          s1_func_ff;
   logic signed [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                          s1_last_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] sample_out_ff;
   logic                          sample_valid_ff;
   logic                          ptt_ff;

   logic                          req_take, advance;
   logic signed [SAMPLE_BITS-1:0] scaled;
   logic [SAMPLE_BITS-1:0]        mag;
   logic                          ptt_nx;

   gmv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gmv_scale u_scale (
      .sample   (s1_sample_ff),
      .gain_q14 (cfg.gain_q14),
      .mute     (cfg.mute),
      .scaled   (scaled),
      .mag      (mag)
   );

   gmv_vox u_vox (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .upd    (advance),
      .tick   (s1_func_ff),
      .last   (s1_last_ff),
      .mag    (mag),
      .ptt_nx (ptt_nx)
   );

   // move the held item forward when the result slot is free or being taken
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff   <= req_func;
         s1_sample_ff <= req_sample_in;
         s1_last_ff   <= req_buffer_end;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sample_out_ff   <= s1_func_ff ? '0 : scaled;
         sample_valid_ff <= !s1_func_ff;
         ptt_ff          <= ptt_nx;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_out   = sample_out_ff;
   assign rsp_sample_valid = sample_valid_ff;
   assign rsp_ptt          = ptt_ff;

   ap_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline could move");

   ap_tick_zero_sample: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !sample_valid_ff) |-> sample_out_ff == '0)
      else $error("tick result carries a nonzero sample");

   ap_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced item did not reach the result register");

endmodule

// File: tb/sv/gain_mute_with_vox_ptt_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gain_mute_with_vox_ptt_tb
// Self-checking bench for the gain, mute and push-to-talk block. It sends
// audio samples and millisecond ticks in bursts and reprograms the settings
// between phases. An internal model predicts each result. Results are
// compared in order while the output side stalls on its own pattern.
// ----------------------------------------------------------------------------
module gain_mute_with_vox_ptt_tb;
   import gmv_pkg::*;

   localparam logic FUNC_AUDIO = 1'b0;
   localparam logic FUNC_TICK  = 1'b1;
   localparam logic [MODE_BITS-1:0]      KEY_MODE_UNDEF = 2'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED     = 3'd7;
   localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));
   localparam int RANDOM_ITEMS = 760;
   localparam int LATENCY      = 2;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          sample_valid;
      logic                          ptt;
   } gain_out_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_func = FUNC_AUDIO;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          req_buffer_end = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_sample_valid;
   logic                          rsp_ptt;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;

   // model state
   cfg_type                regs;
   logic [SAMPLE_BITS-1:0] peak_mag;
   logic [SINCE_BITS-1:0]  ms_since_voice;
   logic                   model_ptt;

   gain_out_type scaled_q[$];
   gain_out_type want;
   int           fail_count = 0;

   // sender and receiver pacing
   int gap_max = 0;
   int burst_left = 0;
   int stall_max = 0;
   int run_left = 0;
   int hold_left = 0;
   int hold_request = 0;

   gain_mute_with_vox_ptt dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_sample_in    (req_sample_in),
      .req_buffer_end   (req_buffer_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_ptt          (rsp_ptt),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scale one item and update the peak, hang count and key state.
   function automatic gain_out_type scale_and_key(input logic tick,
                                                  input logic signed [SAMPLE_BITS-1:0] smp,
                                                  input logic last);
      gain_out_type r;
      longint       prod;
      int           mag;
      r.sample_out   = '0;
      r.sample_valid = 1'b0;
      if (regs.key_mode != KEY_MODE_VOX)
         model_ptt = regs.ptt_armed;
      if (tick) begin
         if (ms_since_voice != SINCE_MAX)
            ms_since_voice = ms_since_voice + 1'b1;
      end else begin
         prod = longint'(smp) * (regs.mute ? longint'(0) : longint'(regs.gain_q14)) + 8192;
         prod = prod >>> GAIN_FRAC;
         if (prod > SAT_HI)
            prod = SAT_HI;
         else if (prod < SAT_LO)
            prod = SAT_LO;
         mag = (prod < 0) ? int'(-prod) : int'(prod);
         if (mag > int'(peak_mag))
            peak_mag = mag[SAMPLE_BITS-1:0];
         if (last) begin
            if (regs.key_mode == KEY_MODE_VOX) begin
               if (peak_mag >= regs.vox_threshold) begin
                  model_ptt      = 1'b1;
                  ms_since_voice = '0;
               end else if (regs.hang_ms == '0) begin
                  model_ptt = 1'b0;
               end else if (model_ptt && ms_since_voice > regs.hang_ms) begin
                  model_ptt = 1'b0;
               end
            end
            peak_mag = '0;
         end
         r.sample_out   = prod[SAMPLE_BITS-1:0];
         r.sample_valid = 1'b1;
      end
      r.ptt = model_ptt;
      return r;
   endfunction

   task automatic send_item(input logic func, input int smp, input logic last);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         repeat ($urandom_range(0, gap_max)) begin
            @(negedge clock);
            req_valid = 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid      = 1'b1;
      req_func       = func;
      req_sample_in  = smp[SAMPLE_BITS-1:0];
      req_buffer_end = last;
      do @(posedge clock); while (req_stall);
      scaled_q.push_back(scale_and_key(func, smp[SAMPLE_BITS-1:0], last));
   endtask

   // Hold the input idle until every predicted result has been seen.
   task automatic wait_results_done();
      @(negedge clock);
      req_valid = 1'b0;
      while (scaled_q.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAIN:      regs.gain_q14      = value[GAIN_BITS-1:0];
         CSR_MUTE:      regs.mute          = value[0];
         CSR_KEY_MODE:  regs.key_mode      = value[MODE_BITS-1:0];
         CSR_PTT_ARMED: regs.ptt_armed     = value[0];
         CSR_THRESHOLD: regs.vox_threshold = value[THR_BITS-1:0];
         CSR_HANG:      regs.hang_ms       = value[HANG_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Compare every result transfer with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (scaled_q.size() == 0) begin
            $error("unexpected result transfer: sample_out %0d ptt %0b",
                   rsp_sample_out, rsp_ptt);
            fail_count++;
         end else begin
            want = scaled_q.pop_front();
            if (rsp_sample_out !== want.sample_out) begin
               $error("sample_out: expected %0d, got %0d", want.sample_out, rsp_sample_out);
               fail_count++;
            end
            if (rsp_sample_valid !== want.sample_valid) begin
               $error("sample_valid: expected %0b, got %0b",
                      want.sample_valid, rsp_sample_valid);
               fail_count++;
            end
            if (rsp_ptt !== want.ptt) begin
               $error("ptt: expected %0b, got %0b", want.ptt, rsp_ptt);
               fail_count++;
            end
         end
      end
   end

   // Receiver: alternate stall and flow runs; a hold request overrides both.
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_stall = 1'b1;
      end else if (stall_max == 0) begin
         rsp_stall = 1'b0;
      end else if (run_left != 0) begin
         run_left--;
      end else begin
         rsp_stall = !rsp_stall;
         run_left  = rsp_stall ? $urandom_range(0, stall_max - 1) : $urandom_range(0, 7);
      end
   end

   task automatic test_reset_defaults();
      send_item(FUNC_AUDIO, 32767, 1'b0);
      send_item(FUNC_AUDIO, -32768, 1'b0);
      send_item(FUNC_TICK, -1, 1'b1);
      send_item(FUNC_AUDIO, 0, 1'b1);
   endtask

   task automatic test_gain_and_mute();
      wait_results_done();
      write_reg(CSR_GAIN, 16'hFFFF);
      send_item(FUNC_AUDIO, -32768, 1'b0);
      send_item(FUNC_AUDIO, 32767, 1'b0);
      // half gain: check rounding of halves toward plus infinity
      wait_results_done();
      write_reg(CSR_GAIN, 16'd8192);
      send_item(FUNC_AUDIO, 1, 1'b0);
      send_item(FUNC_AUDIO, -1, 1'b0);
      send_item(FUNC_AUDIO, 3, 1'b1);
      wait_results_done();
      write_reg(CSR_GAIN, 16'd0);
      send_item(FUNC_AUDIO, 12345, 1'b0);
      wait_results_done();
      write_reg(CSR_GAIN, GAIN_RESET);
      write_reg(CSR_MUTE, 16'd1);
      send_item(FUNC_AUDIO, -32768, 1'b1);
      wait_results_done();
      write_reg(CSR_MUTE, 16'd0);
   endtask

   task automatic test_manual_modes();
      wait_results_done();
      write_reg(CSR_PTT_ARMED, 16'd1);
      write_reg(CSR_KEY_MODE, CSR_DATA_BITS'(KEY_MODE_SERIAL));
      send_item(FUNC_AUDIO, 500, 1'b1);
      wait_results_done();
      write_reg(CSR_KEY_MODE, CSR_DATA_BITS'(KEY_MODE_UNDEF));
      write_reg(CSR_UNUSED, 16'd0);
      send_item(FUNC_TICK, 0, 1'b0);
      wait_results_done();
      write_reg(CSR_KEY_MODE, CSR_DATA_BITS'(KEY_MODE_HID));
      write_reg(CSR_PTT_ARMED, 16'd0);
      send_item(FUNC_AUDIO, -7, 1'b0);
      wait_results_done();
      write_reg(CSR_PTT_ARMED, 16'd1);
      send_item(FUNC_AUDIO, 7, 1'b0);
   endtask

   task automatic test_vox_keying();
      wait_results_done();
      // entering voice mode keeps the key on until the first buffer end
      write_reg(CSR_PTT_ARMED, 16'd0);
      write_reg(CSR_KEY_MODE, CSR_DATA_BITS'(KEY_MODE_VOX));
      write_reg(CSR_HANG, 16'd3);
      send_item(FUNC_AUDIO, 100, 1'b1);
      send_item(FUNC_AUDIO, 2000, 1'b0);
      send_item(FUNC_AUDIO, 5, 1'b1);
      send_item(FUNC_TICK, 0, 1'b0);
      send_item(FUNC_TICK, 0, 1'b0);
      send_item(FUNC_AUDIO, 0, 1'b1);
      send_item(FUNC_TICK, 0, 1'b1);
      send_item(FUNC_TICK, 0, 1'b0);
      send_item(FUNC_AUDIO, 0, 1'b1);
      // zero hang: drop at the first quiet buffer end
      wait_results_done();
      write_reg(CSR_HANG, 16'd0);
      write_reg(CSR_THRESHOLD, 16'd32768);
      send_item(FUNC_AUDIO, -32768, 1'b1);
      send_item(FUNC_AUDIO, 32767, 1'b1);
      wait_results_done();
      write_reg(CSR_THRESHOLD, 16'd0);
      send_item(FUNC_AUDIO, 0, 1'b1);
      wait_results_done();
      write_reg(CSR_THRESHOLD, 16'hFFFF);
      send_item(FUNC_AUDIO, -32768, 1'b1);
   endtask

   task automatic randomize_regs();
      int sel;
      sel = $urandom_range(0, 7);
      write_reg(CSR_GAIN, (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
                (sel < 5) ? GAIN_RESET : 16'($urandom));
      write_reg(CSR_MUTE, ($urandom_range(0, 5) == 0) ? 16'd1 : 16'd0);
      sel = $urandom_range(0, 9);
      write_reg(CSR_KEY_MODE, CSR_DATA_BITS'((sel < 2) ? KEY_MODE_HID :
                (sel == 2) ? KEY_MODE_SERIAL :
                (sel == 3) ? KEY_MODE_UNDEF : KEY_MODE_VOX));
      write_reg(CSR_PTT_ARMED, 16'($urandom_range(0, 1)));
      sel = $urandom_range(0, 7);
      write_reg(CSR_THRESHOLD, (sel == 0) ? 16'd0 : (sel == 1) ? 16'd32768 :
                (sel == 2) ? 16'($urandom_range(32769, 65535)) :
                16'($urandom_range(0, 32768) >> $urandom_range(0, 8)));
      sel = $urandom_range(0, 7);
      write_reg(CSR_HANG, (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF :
                16'($urandom_range(1, 12)));
   endtask

   task automatic test_random_traffic();
      int sent;
      int phase_end;
      int len;
      int amp;
      int v;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_results_done();
         randomize_regs();
         gap_max   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         stall_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         phase_end = sent + $urandom_range(30, 70);
         while (sent < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: any field combination
               send_item(1'($urandom_range(0, 1)), int'($urandom),
                         1'($urandom_range(0, 1)));
               sent++;
            end else begin
               repeat ($urandom_range(0, (regs.hang_ms < 12) ? int'(regs.hang_ms) + 2 : 4)) begin
                  send_item(FUNC_TICK, int'($urandom), 1'($urandom_range(0, 1)));
                  sent++;
               end
               len = $urandom_range(1, 10);
               amp = 1 << $urandom_range(0, 15);
               if ($urandom_range(0, 5) == 0)
                  amp = 32768;
               for (int i = 0; i < len; i++) begin
                  v = int'($urandom_range(0, 2 * amp)) - amp;
                  if (v > 32767)
                     v = 32767;
                  send_item(FUNC_AUDIO, v, i == len - 1);
                  sent++;
               end
            end
         end
      end
   endtask

   task automatic test_backpressure();
      wait_results_done();
      gap_max   = 0;
      stall_max = 0;
      write_reg(CSR_KEY_MODE, CSR_DATA_BITS'(KEY_MODE_VOX));
      write_reg(CSR_HANG, 16'd5);
      write_reg(CSR_THRESHOLD, 16'd4000);
      @(posedge clock);
      hold_request = 300;
      for (int i = 0; i < 40; i++)
         send_item((i % 7 == 6) ? FUNC_TICK : FUNC_AUDIO,
                   int'($urandom_range(0, 16000)) - 8000, i % 5 == 4);
      wait_results_done();
   endtask

   initial begin
      regs.gain_q14      = GAIN_RESET;
      regs.mute          = 1'b0;
      regs.key_mode      = KEY_MODE_HID;
      regs.ptt_armed     = 1'b0;
      regs.vox_threshold = THR_RESET;
      regs.hang_ms       = HANG_RESET;
      peak_mag           = '0;
      ms_since_voice     = SINCE_MAX;
      model_ptt          = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_gain_and_mute();
      test_manual_modes();
      test_vox_keying();
      gap_max   = 4;
      stall_max = 6;
      test_random_traffic();
      test_backpressure();

      wait_results_done();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("FAILURE");
      $finish;
   end

endmodule
